/* hdl/tksl_pkg.sv */
// Shared types and constants for the top-k score list.
// No dependencies; used by tksl_cell, top_k_score_list_top and tb.
package tksl_pkg;

  localparam int SCORE_W     = 32;
  localparam int LIST_DEPTH  = 64;
  localparam int INDEX_WIDTH = 16;
  localparam int COUNT_W     = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic signed [SCORE_W-1:0] SCORE_MIN = 32'sh8000_0000;

  localparam logic signed [SCORE_W-1:0] THR_RESET      = SCORE_MIN;
  localparam logic [COUNT_W-1:0]        AT_LEAST_RESET = 7'd1;
  localparam logic [COUNT_W-1:0]        AT_MOST_RESET  = 7'd64;

  typedef enum logic [0:0] {
    OP_OFFER = 1'b0,
    OP_DUMP  = 1'b1
  } op_e;

  typedef enum logic [0:0] {
    KIND_STATUS = 1'b0,
    KIND_ENTRY  = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD    = 2'd0,
    CFG_AT_LEAST     = 2'd1,
    CFG_AT_MOST      = 2'd2,
    CFG_SELF_SIMILAR = 2'd3
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_CMP  = 2'd1,
    CELL_INS  = 2'd2,
    CELL_ROT  = 2'd3
  } cell_cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'd0,
    ST_CMP  = 3'd1,
    ST_UPD  = 3'd2,
    ST_CNT  = 3'd3,
    ST_RESP = 3'd4,
    ST_DUMP = 3'd5
  } state_e;

  typedef struct packed {
    logic valid;   // cell holds a list entry
    logic ge;      // valid and entry score >= offered score
    logic ge_thr;  // entry score >= threshold
    logic kept;    // new entry lands here and survives pruning
  } cell_flags_t;

endpackage

/* hdl/tksl_cell.sv */
// One slot of the sorted insertion chain: entry storage, compares, shift/rotate.
// Depends on tksl_pkg.
module tksl_cell #(
  parameter int Idx        = 0,
  parameter int CmpW       = tksl_pkg::COUNT_W,
  parameter int IndexWidth = tksl_pkg::INDEX_WIDTH
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  tksl_pkg::cell_cmd_e                   cmd_i,
  input  logic signed [tksl_pkg::SCORE_W-1:0]   sc_i,
  input  logic [IndexWidth-1:0]                 query_i,
  input  logic [IndexWidth-1:0]                 target_i,
  input  logic signed [tksl_pkg::SCORE_W-1:0]   thr_i,
  input  logic                                  sc_ge_thr_i,
  input  logic [tksl_pkg::COUNT_W-1:0]          at_least_i,
  input  logic [tksl_pkg::COUNT_W-1:0]          at_most_i,
  input  logic signed [tksl_pkg::SCORE_W-1:0]   prev_score_i,
  input  logic [IndexWidth-1:0]                 prev_query_i,
  input  logic [IndexWidth-1:0]                 prev_target_i,
  input  tksl_pkg::cell_flags_t                 prev_flags_i,
  input  logic signed [tksl_pkg::SCORE_W-1:0]   next_score_i,
  input  logic [IndexWidth-1:0]                 next_query_i,
  input  logic [IndexWidth-1:0]                 next_target_i,
  input  logic                                  next_valid_i,
  input  logic signed [tksl_pkg::SCORE_W-1:0]   head_score_i,
  input  logic [IndexWidth-1:0]                 head_query_i,
  input  logic [IndexWidth-1:0]                 head_target_i,
  output logic signed [tksl_pkg::SCORE_W-1:0]   score_o,
  output logic [IndexWidth-1:0]                 query_o,
  output logic [IndexWidth-1:0]                 target_o,
  output tksl_pkg::cell_flags_t                 flags_o
);

  localparam logic [CmpW-1:0] IdxC = CmpW'(Idx);

  logic signed [tksl_pkg::SCORE_W-1:0] score_q, score_d;
  logic [IndexWidth-1:0]               query_q, query_d;
  logic [IndexWidth-1:0]               target_q, target_d;
  logic valid_q, valid_d;
  logic ge_q, ge_d;
  logic gthr_q, gthr_d;

  logic ins_here, take_prev;
  logic signed [tksl_pkg::SCORE_W-1:0] new_score;
  logic [IndexWidth-1:0]               new_query, new_target;
  logic new_gthr, new_valid;

  // Insertion point: predecessor scores >= offer, this one does not.
  assign ins_here  = !ge_q && prev_flags_i.ge;
  assign take_prev = !ge_q && !prev_flags_i.ge;

  always_comb begin
    new_score  = score_q;
    new_query  = query_q;
    new_target = target_q;
    new_gthr   = gthr_q;
    if (ins_here) begin
      new_score  = sc_i;
      new_query  = query_i;
      new_target = target_i;
      new_gthr   = sc_ge_thr_i;
    end else if (take_prev) begin
      new_score  = prev_score_i;
      new_query  = prev_query_i;
      new_target = prev_target_i;
      new_gthr   = prev_flags_i.ge_thr;
    end
    // list grows by one, then cut at the limit, then prune below threshold
    new_valid = (valid_q || prev_flags_i.valid)
                && (CmpW'(at_most_i) > IdxC)
                && ((CmpW'(at_least_i) > IdxC) || new_gthr);
  end

  always_comb begin
    score_d  = score_q;
    query_d  = query_q;
    target_d = target_q;
    valid_d  = valid_q;
    ge_d     = ge_q;
    gthr_d   = gthr_q;
    unique case (cmd_i)
      tksl_pkg::CELL_HOLD: begin
      end
      tksl_pkg::CELL_CMP: begin
        ge_d   = valid_q && (score_q >= sc_i);
        gthr_d = score_q >= thr_i;
      end
      tksl_pkg::CELL_INS: begin
        score_d  = new_score;
        query_d  = new_query;
        target_d = new_target;
        gthr_d   = new_gthr;
        valid_d  = new_valid;
      end
      tksl_pkg::CELL_ROT: begin
        // valid part of the chain rotates toward the head
        if (next_valid_i) begin
          score_d  = next_score_i;
          query_d  = next_query_i;
          target_d = next_target_i;
        end else begin
          score_d  = head_score_i;
          query_d  = head_query_i;
          target_d = head_target_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      ge_q    <= 1'b0;
      gthr_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      ge_q    <= ge_d;
      gthr_q  <= gthr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q  <= score_d;
    query_q  <= query_d;
    target_q <= target_d;
  end

  assign score_o        = score_q;
  assign query_o        = query_q;
  assign target_o       = target_q;
  assign flags_o.valid  = valid_q;
  assign flags_o.ge     = ge_q;
  assign flags_o.ge_thr = gthr_q;
  assign flags_o.kept   = ins_here && new_valid;

endmodule

/* hdl/top_k_score_list_top.sv */
// Top-k score list: control FSM, config registers, output register, cell chain.
// Offer: accepted, then compare, insert, count and respond; the next item is taken only after
// the result is loaded into the output register, so an output stall holds the respond state.
// Dump: one result per cycle while the output is not stalled, max(count,1) results, then idle; head entry first.
// Reset: list empty, registers at defaults; entry storage is not cleared.
// Depends on tksl_pkg and tksl_cell.
module top_k_score_list_top #(
  parameter int ListDepth  = tksl_pkg::LIST_DEPTH,
  parameter int IndexWidth = tksl_pkg::INDEX_WIDTH
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // config write
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [tksl_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [tksl_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // requests
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  logic                                 operation_i,
  input  logic signed [tksl_pkg::SCORE_W-1:0]  score_i,
  input  logic [IndexWidth-1:0]                query_index_i,
  input  logic [IndexWidth-1:0]                target_index_i,
  // results
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic                                 result_kind_o,
  output logic                                 accepted_o,
  output logic                                 entry_valid_o,
  output logic [tksl_pkg::COUNT_W-1:0]         list_count_o,
  output logic signed [tksl_pkg::SCORE_W-1:0]  entry_score_o,
  output logic [IndexWidth-1:0]                entry_query_o,
  output logic [IndexWidth-1:0]                entry_target_o,
  output logic                                 last_of_run_o
);

  localparam int CntW   = $clog2(ListDepth + 1);
  localparam int CountW = tksl_pkg::COUNT_W;
  localparam int CmpW   = (CntW > CountW) ? CntW : CountW;
  localparam int ScW    = tksl_pkg::SCORE_W;

  // config registers
  logic signed [ScW-1:0] thr_q;
  logic [CountW-1:0]     at_least_q, at_most_q;
  logic                  self_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q      <= tksl_pkg::THR_RESET;
      at_least_q <= tksl_pkg::AT_LEAST_RESET;
      at_most_q  <= tksl_pkg::AT_MOST_RESET;
      self_q     <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        tksl_pkg::CFG_THRESHOLD:    thr_q      <= cfg_data_i[ScW-1:0];
        tksl_pkg::CFG_AT_LEAST:     at_least_q <= cfg_data_i[CountW-1:0];
        tksl_pkg::CFG_AT_MOST:      at_most_q  <= cfg_data_i[CountW-1:0];
        tksl_pkg::CFG_SELF_SIMILAR: self_q     <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // request registers
  tksl_pkg::state_e      state_q, state_d;
  logic                  op_q;
  logic signed [ScW-1:0] sc_q;
  logic [IndexWidth-1:0] qry_q, tgt_q;
  logic                  sc_ge_thr_q;
  logic                  accepted_q;
  logic [CntW-1:0]       cnt_q, dcnt_q;

  // cell chain
  tksl_pkg::cell_cmd_e   cell_cmd;
  logic signed [ScW-1:0] c_score [ListDepth];
  logic [IndexWidth-1:0] c_query [ListDepth];
  logic [IndexWidth-1:0] c_target[ListDepth];
  tksl_pkg::cell_flags_t c_flags [ListDepth];

  for (genvar i = 0; i < ListDepth; i++) begin : g_cell
    logic signed [ScW-1:0] p_score, n_score;
    logic [IndexWidth-1:0] p_query, p_target, n_query, n_target;
    tksl_pkg::cell_flags_t p_flags;
    logic                  n_valid;

    if (i == 0) begin : g_head
      assign p_score  = sc_q;
      assign p_query  = qry_q;
      assign p_target = tgt_q;
      assign p_flags  = '{valid: 1'b1, ge: 1'b1, ge_thr: 1'b1, kept: 1'b0};
    end else begin : g_body
      assign p_score  = c_score[i-1];
      assign p_query  = c_query[i-1];
      assign p_target = c_target[i-1];
      assign p_flags  = c_flags[i-1];
    end

    if (i == ListDepth - 1) begin : g_tail
      assign n_score  = c_score[0];
      assign n_query  = c_query[0];
      assign n_target = c_target[0];
      assign n_valid  = 1'b0;
    end else begin : g_inner
      assign n_score  = c_score[i+1];
      assign n_query  = c_query[i+1];
      assign n_target = c_target[i+1];
      assign n_valid  = c_flags[i+1].valid;
    end

    tksl_cell #(
      .Idx       (i),
      .CmpW      (CmpW),
      .IndexWidth(IndexWidth)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cell_cmd),
      .sc_i         (sc_q),
      .query_i      (qry_q),
      .target_i     (tgt_q),
      .thr_i        (thr_q),
      .sc_ge_thr_i  (sc_ge_thr_q),
      .at_least_i   (at_least_q),
      .at_most_i    (at_most_q),
      .prev_score_i (p_score),
      .prev_query_i (p_query),
      .prev_target_i(p_target),
      .prev_flags_i (p_flags),
      .next_score_i (n_score),
      .next_query_i (n_query),
      .next_target_i(n_target),
      .next_valid_i (n_valid),
      .head_score_i (c_score[0]),
      .head_query_i (c_query[0]),
      .head_target_i(c_target[0]),
      .score_o      (c_score[i]),
      .query_o      (c_query[i]),
      .target_o     (c_target[i]),
      .flags_o      (c_flags[i])
    );
  end

  // reductions over the chain flags
  logic [ListDepth:0] valid_vec;
  logic               all_ge, floor_ok, kept_any, therm_ok;
  logic [CntW-1:0]    cnt_enc;

  always_comb begin
    all_ge   = 1'b1;
    floor_ok = CmpW'(at_least_q) <= CmpW'(ListDepth);
    kept_any = 1'b0;
    valid_vec = '0;
    for (int i = 0; i < ListDepth; i++) begin
      valid_vec[i] = c_flags[i].valid;
      all_ge       = all_ge && (!c_flags[i].valid || c_flags[i].ge);
      if ((CmpW'(at_least_q) > CmpW'(i)) && !c_flags[i].valid) begin
        floor_ok = 1'b0;
      end
      kept_any = kept_any || c_flags[i].kept;
    end
    cnt_enc  = '0;
    therm_ok = 1'b1;
    for (int i = 0; i < ListDepth; i++) begin
      if (valid_vec[i] && !valid_vec[i+1]) begin
        cnt_enc = cnt_enc | CntW'(i + 1);
      end
      if (valid_vec[i+1] && !valid_vec[i]) begin
        therm_ok = 1'b0;
      end
    end
  end

  // sc <= last kept score: empty list keeps the minimum score
  logic le_last, drop, no_room, do_ins;
  assign le_last = c_flags[0].valid ? all_ge : (sc_q == tksl_pkg::SCORE_MIN);
  assign drop    = (self_q && (qry_q <= tgt_q)) || (!sc_ge_thr_q && le_last && floor_ok);
  assign no_room = c_flags[ListDepth-1].ge;
  assign do_ins  = !drop && !no_room;

  // output register
  logic                  out_valid_q;
  logic                  kind_q, acc_out_q, ev_q, last_q;
  logic [CountW-1:0]     lc_q;
  logic signed [ScW-1:0] es_q;
  logic [IndexWidth-1:0] eq_q, et_q;
  logic                  out_free, out_load;
  logic                  dump_last, list_empty;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign list_empty = (cnt_q == '0);
  assign dump_last  = list_empty || (CntW'(dcnt_q + CntW'(1)) == cnt_q);

  always_comb begin
    state_d    = state_q;
    cell_cmd   = tksl_pkg::CELL_HOLD;
    in_stall_o = 1'b1;
    out_load   = 1'b0;
    unique case (state_q)
      tksl_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          state_d = (operation_i == tksl_pkg::OP_DUMP) ? tksl_pkg::ST_DUMP : tksl_pkg::ST_CMP;
        end
      end
      tksl_pkg::ST_CMP: begin
        cell_cmd = tksl_pkg::CELL_CMP;
        state_d  = tksl_pkg::ST_UPD;
      end
      tksl_pkg::ST_UPD: begin
        cell_cmd = do_ins ? tksl_pkg::CELL_INS : tksl_pkg::CELL_HOLD;
        state_d  = tksl_pkg::ST_CNT;
      end
      tksl_pkg::ST_CNT: begin
        state_d = tksl_pkg::ST_RESP;
      end
      tksl_pkg::ST_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = tksl_pkg::ST_IDLE;
        end
      end
      tksl_pkg::ST_DUMP: begin
        if (out_free) begin
          out_load = 1'b1;
          if (!list_empty) begin
            cell_cmd = tksl_pkg::CELL_ROT;
          end
          if (dump_last) begin
            state_d = tksl_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = tksl_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tksl_pkg::ST_IDLE;
      cnt_q       <= '0;
      dcnt_q      <= '0;
      accepted_q  <= 1'b0;
      sc_ge_thr_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == tksl_pkg::ST_CMP) begin
        sc_ge_thr_q <= sc_q >= thr_q;
      end
      if (state_q == tksl_pkg::ST_UPD) begin
        accepted_q <= do_ins && kept_any;
      end
      if (state_q == tksl_pkg::ST_CNT) begin
        cnt_q <= cnt_enc;
      end
      if (state_q == tksl_pkg::ST_IDLE) begin
        dcnt_q <= '0;
      end else if (state_q == tksl_pkg::ST_DUMP && out_load) begin
        dcnt_q <= CntW'(dcnt_q + CntW'(1));
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == tksl_pkg::ST_IDLE && in_valid_i) begin
      op_q  <= operation_i;
      sc_q  <= score_i;
      qry_q <= query_index_i;
      tgt_q <= target_index_i;
    end
    if (out_load) begin
      lc_q <= CountW'(cnt_q);
      if (state_q == tksl_pkg::ST_DUMP) begin
        kind_q    <= tksl_pkg::KIND_ENTRY;
        acc_out_q <= 1'b0;
        ev_q      <= !list_empty;
        es_q      <= list_empty ? '0 : c_score[0];
        eq_q      <= list_empty ? '0 : c_query[0];
        et_q      <= list_empty ? '0 : c_target[0];
        last_q    <= dump_last;
      end else begin
        kind_q    <= tksl_pkg::KIND_STATUS;
        acc_out_q <= accepted_q;
        ev_q      <= 1'b0;
        es_q      <= '0;
        eq_q      <= '0;
        et_q      <= '0;
        last_q    <= 1'b1;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_kind_o  = kind_q;
  assign accepted_o     = acc_out_q;
  assign entry_valid_o  = ev_q;
  assign list_count_o   = lc_q;
  assign entry_score_o  = es_q;
  assign entry_query_o  = eq_q;
  assign entry_target_o = et_q;
  assign last_of_run_o  = last_q;

  // the incoming op picks the branch taken out of idle; cross-check it against the latched op
  a_op_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tksl_pkg::ST_CMP) |-> (op_q == tksl_pkg::OP_OFFER))
    else $error("offer path entered with dump request");

  a_valid_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    therm_ok)
    else $error("cell valid bits are not a prefix of the chain");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(ListDepth))
    else $error("list count beyond depth");

  a_entry_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && entry_valid_o) |->
      (result_kind_o == tksl_pkg::KIND_ENTRY && list_count_o != '0 && !accepted_o))
    else $error("entry result with inconsistent status fields");

endmodule

/* test/tb.sv */
// Self-checking testbench for top_k_score_list_top: sorted insertion, pruning and dumps.
// Keeps its own copy of the score list to predict every result. Depends on tksl_pkg
// and the top_k_score_list_top RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tksl_pkg::*;

  localparam int IW = INDEX_WIDTH;

  typedef struct packed {
    kind_e                     kind;
    logic                      accepted;
    logic                      entry_valid;
    logic [COUNT_W-1:0]        count;
    logic signed [SCORE_W-1:0] score;
    logic [IW-1:0]             query;
    logic [IW-1:0]             target;
    logic                      last;
  } list_result_t;

  class top_k_tracker;
    logic signed [SCORE_W-1:0] kept_score [LIST_DEPTH];
    logic [IW-1:0]             kept_query [LIST_DEPTH];
    logic [IW-1:0]             kept_target[LIST_DEPTH];
    int                        held;
    logic signed [SCORE_W-1:0] last_kept;
    logic signed [SCORE_W-1:0] thr;
    int                        at_least;
    int                        at_most;
    bit                        self_sim;
    list_result_t              awaited_results[$];
    int                        errors;

    function new();
      held      = 0;
      last_kept = SCORE_MIN;
      thr       = THR_RESET;
      at_least  = int'(AT_LEAST_RESET);
      at_most   = int'(AT_MOST_RESET);
      self_sim  = 1'b0;
      errors    = 0;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function void write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_THRESHOLD:    thr = signed'(data[SCORE_W-1:0]);
        CFG_AT_LEAST:     at_least = int'(data[COUNT_W-1:0]);
        CFG_AT_MOST:      at_most = int'(data[COUNT_W-1:0]);
        CFG_SELF_SIMILAR: self_sim = data[0];
        default: ;
      endcase
    endfunction

    function void push_result(kind_e kind, logic acc, logic ev, logic signed [SCORE_W-1:0] sc,
                              logic [IW-1:0] q, logic [IW-1:0] t, logic last);
      list_result_t r;
      r.kind        = kind;
      r.accepted    = acc;
      r.entry_valid = ev;
      r.count       = COUNT_W'(held);
      r.score       = sc;
      r.query       = q;
      r.target      = t;
      r.last        = last;
      awaited_results.push_back(r);
    endfunction

    // Dump or insert an offer; ties land after equal entries, then cut and prune the tail.
    function void record_request(op_e op, logic signed [SCORE_W-1:0] sc, logic [IW-1:0] q,
                                 logic [IW-1:0] t);
      bit drop;
      bit acc;
      int pos;
      int top;
      int limit;
      if (op == OP_DUMP) begin
        if (held == 0) begin
          push_result(KIND_ENTRY, 1'b0, 1'b0, '0, '0, '0, 1'b1);
        end else begin
          for (int k = 0; k < held; k++)
            push_result(KIND_ENTRY, 1'b0, 1'b1, kept_score[k], kept_query[k], kept_target[k],
                        k + 1 == held);
        end
        return;
      end
      acc  = 1'b0;
      drop = (self_sim && q <= t) ||
             (sc < thr && sc <= last_kept && held >= at_least);
      if (!drop) begin
        pos = 0;
        while (pos < held && kept_score[pos] >= sc) pos++;
        if (pos < LIST_DEPTH) begin
          top = (held < LIST_DEPTH) ? held : LIST_DEPTH - 1;
          for (int k = top; k > pos; k--) begin
            kept_score[k]  = kept_score[k-1];
            kept_query[k]  = kept_query[k-1];
            kept_target[k] = kept_target[k-1];
          end
          kept_score[pos]  = sc;
          kept_query[pos]  = q;
          kept_target[pos] = t;
          held  = top + 1;
          limit = (at_most < LIST_DEPTH) ? at_most : LIST_DEPTH;
          if (held > limit) held = limit;
          while (held > at_least && held > 0 && kept_score[held-1] < thr) held--;
          acc = pos < held;
        end
        last_kept = (held > 0) ? kept_score[held-1] : SCORE_MIN;
      end
      push_result(KIND_STATUS, acc, 1'b0, '0, '0, '0, 1'b1);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, seen);
        errors++;
      end
    endfunction

    function void check_result(list_result_t got);
      list_result_t want;
      if (awaited_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d count %0d",
                 $time, got.kind, got.count);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("result_kind", 32'(want.kind), 32'(got.kind));
      compare_field("accepted", 32'(want.accepted), 32'(got.accepted));
      compare_field("entry_valid", 32'(want.entry_valid), 32'(got.entry_valid));
      compare_field("list_count", 32'(want.count), 32'(got.count));
      compare_field("entry_score", 32'(want.score), 32'(got.score));
      compare_field("entry_query", 32'(want.query), 32'(got.query));
      compare_field("entry_target", 32'(want.target), 32'(got.target));
      compare_field("last_of_run", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic                      clk_i;
  logic                      rst_ni;
  logic                      cfg_valid_i;
  logic                      cfg_ready_o;
  logic [CFG_IDX_W-1:0]      cfg_index_i;
  logic [CFG_DATA_W-1:0]     cfg_data_i;
  logic                      in_valid_i;
  logic                      in_stall_o;
  logic                      operation_i;
  logic signed [SCORE_W-1:0] score_i;
  logic [IW-1:0]             query_index_i;
  logic [IW-1:0]             target_index_i;
  logic                      out_valid_o;
  logic                      out_stall_i;
  logic                      result_kind_o;
  logic                      accepted_o;
  logic                      entry_valid_o;
  logic [COUNT_W-1:0]        list_count_o;
  logic signed [SCORE_W-1:0] entry_score_o;
  logic [IW-1:0]             entry_query_o;
  logic [IW-1:0]             entry_target_o;
  logic                      last_of_run_o;

  top_k_tracker              sb;
  logic signed [SCORE_W-1:0] recent_score;
  bit                        self_mode;

  top_k_score_list_top DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .score_i        (score_i),
    .query_index_i  (query_index_i),
    .target_index_i (target_index_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .result_kind_o  (result_kind_o),
    .accepted_o     (accepted_o),
    .entry_valid_o  (entry_valid_o),
    .list_count_o   (list_count_o),
    .entry_score_o  (entry_score_o),
    .entry_query_o  (entry_query_o),
    .entry_target_o (entry_target_o),
    .last_of_run_o  (last_of_run_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin : result_check
    list_result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.kind        = kind_e'(result_kind_o);
      got.accepted    = accepted_o;
      got.entry_valid = entry_valid_o;
      got.count       = list_count_o;
      got.score       = entry_score_o;
      got.query       = entry_query_o;
      got.target      = entry_target_o;
      got.last        = last_of_run_o;
      sb.check_result(got);
    end
  end

  // Output back-pressure: calm stretches, short bursts, occasional long stalls.
  initial begin
    int r;
    out_stall_i = 1'b0;
    @(posedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      if (r < 30) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(10, 60)) @(posedge clk_i);
      end else if (r < 93) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(10, 40)) @(posedge clk_i);
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] with_junk(int val, int w);
    logic [CFG_DATA_W-1:0] d;
    d = CFG_DATA_W'(val);
    // upper bits of narrow registers must be ignored
    if ($urandom_range(0, 1) == 1) d = d | (CFG_DATA_W'($urandom()) << w);
    return d;
  endfunction

  task automatic send_request(op_e op, logic signed [SCORE_W-1:0] sc, logic [IW-1:0] q,
                              logic [IW-1:0] t);
    int gap;
    operation_i    <= op;
    score_i        <= sc;
    query_index_i  <= q;
    target_index_i <= t;
    in_valid_i     <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.record_request(op, sc, q, t);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic offer(logic signed [SCORE_W-1:0] sc, logic [IW-1:0] q, logic [IW-1:0] t);
    send_request(OP_OFFER, sc, q, t);
  endtask

  task automatic dump_list();
    send_request(OP_DUMP, SCORE_W'($urandom()), IW'($urandom()), IW'($urandom()));
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic set_config(logic signed [SCORE_W-1:0] thr, int at_least, int at_most,
                            bit self_sim);
    logic [CFG_DATA_W-1:0] data [4];
    data[0] = thr;
    data[1] = with_junk(at_least, COUNT_W);
    data[2] = with_junk(at_most, COUNT_W);
    data[3] = with_junk(int'(self_sim), 1);
    for (int i = 0; i < 4; i++) begin
      cfg_index_i <= cfg_reg_e'(i);
      cfg_data_i  <= data[i];
      cfg_valid_i <= 1'b1;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      sb.write_reg(cfg_reg_e'(i), data[i]);
    end
    cfg_valid_i <= 1'b0;
    self_mode = self_sim;
  endtask

  function automatic logic signed [SCORE_W-1:0] pick_score();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return SCORE_W'(int'($urandom_range(0, 6000)) - 3000);
    if (r < 45) begin
      case ($urandom_range(0, 3))
        0:       return SCORE_MIN;
        1:       return 32'sh7fff_ffff;
        2:       return -32'sd1;
        default: return '0;
      endcase
    end
    if (r < 60) return recent_score;
    return SCORE_W'($urandom());
  endfunction

  task automatic random_config();
    logic signed [SCORE_W-1:0] thr;
    int at_least;
    int at_most;
    case ($urandom_range(0, 5))
      0:       thr = SCORE_MIN;
      1:       thr = 32'sh7fff_ffff;
      2:       thr = '0;
      3, 4:    thr = SCORE_W'(int'($urandom_range(0, 4000)) - 2000);
      default: thr = SCORE_W'($urandom());
    endcase
    case ($urandom_range(0, 4))
      0:       at_least = 0;
      1:       at_least = 64;
      2:       at_least = 1;
      default: at_least = $urandom_range(0, 20);
    endcase
    case ($urandom_range(0, 5))
      0:       at_most = 1;
      1:       at_most = 64;
      2:       at_most = 127;
      3:       at_most = 0;
      default: at_most = $urandom_range(2, 24);
    endcase
    set_config(thr, at_least, at_most, $urandom_range(0, 99) < 30);
  endtask

  task automatic run_phase(int n);
    logic [IW-1:0] q;
    logic [IW-1:0] t;
    logic signed [SCORE_W-1:0] sc;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 8) begin
        dump_list();
      end else begin
        if (self_mode && $urandom_range(0, 99) < 85) begin
          t = IW'($urandom_range(0, 65534));
          q = IW'($urandom_range(int'(t) + 1, 65535));
        end else begin
          q = IW'($urandom());
          t = ($urandom_range(0, 9) == 0) ? q : IW'($urandom());
        end
        sc = pick_score();
        recent_score = sc;
        offer(sc, q, t);
      end
    end
    dump_list();
    drain();
  endtask

  initial begin
    rst_ni         = 1'b0;
    cfg_valid_i    = 1'b0;
    cfg_index_i    = CFG_THRESHOLD;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    operation_i    = OP_OFFER;
    score_i        = '0;
    query_index_i  = '0;
    target_index_i = '0;
    recent_score   = '0;
    self_mode      = 1'b0;
    sb = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: empty dump, extremes, ties at head and tail
    dump_list();
    offer(32'sh7fff_ffff, 16'hffff, 16'h0000);
    offer(SCORE_MIN, 16'h0000, 16'hffff);
    offer(32'sh7fff_ffff, 16'h0001, 16'h0002);
    offer(32'sh0000_0000, 16'haaaa, 16'h5555);
    offer(SCORE_MIN, 16'h5555, 16'haaaa);
    dump_list();
    drain();

    // self-similar drops and a below-threshold drop, with a limit of two entries
    set_config(32'sh0, 0, 2, 1'b1);
    offer(32'sh0000_0064, 16'd5, 16'd5);
    offer(32'sh0000_0064, 16'd4, 16'd9);
    offer(32'sh0000_0100, 16'd9, 16'd4);
    offer(-32'sd5, 16'd9, 16'd1);
    dump_list();
    drain();

    // zero limit empties the list on insertion
    set_config(SCORE_MIN, 0, 0, 1'b0);
    offer(32'sh0000_0007, 16'd3, 16'd8);
    dump_list();
    drain();

    // oversized limit, keep-at-least above what is held, threshold at max
    set_config(32'sh7fff_ffff, 64, 127, 1'b0);
    offer(-32'sd1, 16'h1234, 16'h4321);
    offer(32'sh7fff_ffff, 16'h8000, 16'h7fff);
    offer(32'sh0000_0005, 16'h00ff, 16'hff00);
    dump_list();
    drain();

    // fill past the list depth so the full-list drop is reached
    set_config(SCORE_MIN, 1, 64, 1'b0);
    run_phase(80);
    repeat (8) begin
      random_config();
      run_phase($urandom_range(15, 25));
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("PASS top_k_score_list_top");
    end else begin
      $display("FAIL top_k_score_list_top");
    end
    $finish;
  end

  initial begin
    #60_000_000;
    $display("FAIL top_k_score_list_top");
    $finish;
  end

endmodule
